### src/nsst_pkg.sv
// ----------------------------------------------------------------------------
// Nested span stack tracker package
// Shared widths, codes and the configuration bundle of the span tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsst_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam int REQ_W  = 2;
	localparam int KIND_W = 2;
	localparam int WORD_W = 64;

	localparam int APB_AW      = 5;
	localparam int APB_DW      = 64;
	localparam int REG_SEL_LSB = 3;
	localparam int REG_SEL_W   = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

	localparam logic [REG_SEL_W-1:0] REG_TRACING_ENABLED = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_SESSION_ACTIVE  = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_THREAD_INDEX    = 2'd2;
	localparam logic [REG_SEL_W-1:0] REG_THREAD_HANDLE   = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_BEGIN = 2'd0,
		KIND_END   = 2'd1,
		KIND_DROP  = 2'd2
	} kind_t;

	typedef struct packed {
		logic              tracing_enabled;
		logic              session_active;
		logic [WORD_W-1:0] thread_index;
		logic [WORD_W-1:0] thread_handle;
	} cfg_t;

endpackage

`default_nettype wire

### src/nsst_if.sv
// ----------------------------------------------------------------------------
// Span tracker stream interfaces
// Request channel and record channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface nsst_req_if;
	logic                           valid;
	logic                           ready;
	logic [nsst_pkg::REQ_W-1:0]     req_type;
	logic [nsst_pkg::WORD_W-1:0]    region_hash;
	logic [nsst_pkg::WORD_W-1:0]    timestamp_ns;

	modport source (output valid, output req_type, output region_hash,
		output timestamp_ns, input ready);
	modport sink (input valid, input req_type, input region_hash,
		input timestamp_ns, output ready);
endinterface

interface nsst_rec_if;
	logic                           valid;
	logic                           ready;
	logic [nsst_pkg::KIND_W-1:0]    record_kind;
	logic [nsst_pkg::WORD_W-1:0]    span_id;
	logic [nsst_pkg::WORD_W-1:0]    parent_id;
	logic [nsst_pkg::WORD_W-1:0]    thread_seq;
	logic [nsst_pkg::WORD_W-1:0]    thread_id;
	logic [nsst_pkg::WORD_W-1:0]    record_time;
	logic                           last;

	modport source (output valid, output record_kind, output span_id,
		output parent_id, output thread_seq, output thread_id,
		output record_time, output last, input ready);
	modport sink (input valid, input record_kind, input span_id,
		input parent_id, input thread_seq, input thread_id,
		input record_time, input last, output ready);
endinterface

`default_nettype wire

### src/nsst_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/nsst_cfg.sv
// ----------------------------------------------------------------------------
// Span tracker configuration registers
// APB-style register file holding the enables and the thread fields.
// ----------------------------------------------------------------------------
`default_nettype none

module nsst_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nsst_pkg::APB_AW-1:0]   paddr,
	input  wire logic [nsst_pkg::APB_DW-1:0]   pwdata,
	output logic      [nsst_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output nsst_pkg::cfg_t                     cfg
);

	logic [nsst_pkg::REG_SEL_W-1:0] sel;
	logic                           wr_en;
	nsst_pkg::cfg_t                 cfg_q;

	assign sel    = paddr[nsst_pkg::REG_SEL_LSB +: nsst_pkg::REG_SEL_W];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (sel)
				nsst_pkg::REG_TRACING_ENABLED: cfg_q.tracing_enabled <= pwdata[0];
				nsst_pkg::REG_SESSION_ACTIVE:  cfg_q.session_active  <= pwdata[0];
				nsst_pkg::REG_THREAD_INDEX:    cfg_q.thread_index    <= pwdata;
				nsst_pkg::REG_THREAD_HANDLE:   cfg_q.thread_handle   <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			nsst_pkg::REG_TRACING_ENABLED:
				prdata = {{(nsst_pkg::APB_DW-1){1'b0}}, cfg_q.tracing_enabled};
			nsst_pkg::REG_SESSION_ACTIVE:
				prdata = {{(nsst_pkg::APB_DW-1){1'b0}}, cfg_q.session_active};
			nsst_pkg::REG_THREAD_INDEX:  prdata = cfg_q.thread_index;
			nsst_pkg::REG_THREAD_HANDLE: prdata = cfg_q.thread_handle;
		endcase
	end

endmodule

`default_nettype wire

### src/nsst_core.sv
// ----------------------------------------------------------------------------
// Span tracker sequencer
// Walks the frame stack one entry at a time and emits span records.
// ----------------------------------------------------------------------------
`default_nettype none

module nsst_core #(
	parameter int STACK_DEPTH = nsst_pkg::STACK_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire nsst_pkg::cfg_t cfg,
	nsst_req_if.sink      req,
	nsst_rec_if.source    rec
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int W  = nsst_pkg::WORD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_RD,
		ST_PUSH_EMIT,
		ST_DROP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_CLOSE_RD,
		ST_CLOSE_EMIT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       keep_q;
	logic [AW-1:0]       idx_q;
	logic [W-1:0]        next_id_q;
	logic [W-1:0]        hash_q;
	logic [W-1:0]        time_q;

	logic                out_valid_q;
	nsst_pkg::kind_t     kind_q;
	logic [W-1:0]        sid_q;
	logic [W-1:0]        parent_q;
	logic [W-1:0]        tseq_q;
	logic [W-1:0]        tid_q;
	logic [W-1:0]        rtime_q;
	logic                last_q;

	logic                can_load;
	logic [AW-1:0]       top_addr;
	logic [AW-1:0]       raddr;
	logic                ram_we;
	logic [2*W-1:0]      rd_data;
	logic                hash_hit;
	logic                close_last;
	logic                load;

	assign can_load   = !out_valid_q || rec.ready;
	assign top_addr   = AW'(count_q - CW'(1));
	assign hash_hit   = rd_data[2*W-1:W] == hash_q;
	assign close_last = count_q == keep_q + CW'(1);
	assign ram_we     = (state_q == ST_PUSH_EMIT) && can_load;
	assign load       = can_load && ((state_q == ST_PUSH_EMIT) || (state_q == ST_DROP)
		|| (state_q == ST_CLOSE_EMIT));

	always_comb begin
		unique case (state_q)
			ST_SRCH_RD, ST_SRCH_CMP: raddr = idx_q;
			default:                 raddr = top_addr;
		endcase
	end

	nsst_ram #(
		.WIDTH (2 * W),
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_frames (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(count_q)),
		.wdata ({hash_q, next_id_q}),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign req.ready          = state_q == ST_IDLE;
	assign rec.valid          = out_valid_q;
	assign rec.record_kind    = kind_q;
	assign rec.span_id        = sid_q;
	assign rec.parent_id      = parent_q;
	assign rec.thread_seq     = tseq_q;
	assign rec.thread_id      = tid_q;
	assign rec.record_time    = rtime_q;
	assign rec.last           = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			keep_q      <= '0;
			idx_q       <= '0;
			next_id_q   <= W'(1);
			hash_q      <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= nsst_pkg::KIND_BEGIN;
			sid_q       <= '0;
			parent_q    <= '0;
			tseq_q      <= '0;
			tid_q       <= '0;
			rtime_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rec.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						hash_q <= req.region_hash;
						time_q <= req.timestamp_ns;
						if (cfg.tracing_enabled) begin
							unique case (req.req_type)
								nsst_pkg::REQ_PUSH: begin
									if (cfg.session_active) begin
										if (count_q >= CW'(STACK_DEPTH)) begin
											state_q <= ST_DROP;
										end else begin
											state_q <= ST_PUSH_RD;
										end
									end
								end
								nsst_pkg::REQ_POP: begin
									if (cfg.session_active && count_q != '0) begin
										idx_q   <= top_addr;
										state_q <= ST_SRCH_RD;
									end
								end
								nsst_pkg::REQ_FLUSH: begin
									if (count_q != '0) begin
										keep_q  <= '0;
										state_q <= ST_CLOSE_RD;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_PUSH_RD: begin
					state_q <= ST_PUSH_EMIT;
				end
				ST_PUSH_EMIT: begin
					if (can_load) begin
						kind_q    <= nsst_pkg::KIND_BEGIN;
						sid_q     <= next_id_q;
						parent_q  <= (count_q == '0) ? '0 : rd_data[W-1:0];
						tseq_q    <= cfg.thread_index;
						tid_q     <= cfg.thread_handle;
						rtime_q   <= time_q;
						last_q    <= 1'b1;
						count_q   <= count_q + CW'(1);
						next_id_q <= next_id_q + W'(1);
						state_q   <= ST_IDLE;
					end
				end
				ST_DROP: begin
					if (can_load) begin
						kind_q   <= nsst_pkg::KIND_DROP;
						sid_q    <= '0;
						parent_q <= '0;
						tseq_q   <= cfg.thread_index;
						tid_q    <= cfg.thread_handle;
						rtime_q  <= time_q;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					if (hash_hit) begin
						keep_q  <= CW'(idx_q);
						state_q <= ST_CLOSE_RD;
					end else if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q - AW'(1);
						state_q <= ST_SRCH_RD;
					end
				end
				ST_CLOSE_RD: begin
					state_q <= ST_CLOSE_EMIT;
				end
				ST_CLOSE_EMIT: begin
					if (can_load) begin
						kind_q   <= nsst_pkg::KIND_END;
						sid_q    <= rd_data[W-1:0];
						parent_q <= '0;
						tseq_q   <= cfg.thread_index;
						tid_q    <= '0;
						rtime_q  <= time_q;
						last_q   <= close_last;
						count_q  <= count_q - CW'(1);
						state_q  <= close_last ? ST_IDLE : ST_CLOSE_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("frame count exceeds stack depth");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_DROP) |-> count_q == CW'(STACK_DEPTH))
		else $error("push dropped while stack not full");

	a_begin_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_PUSH_EMIT) |=> count_q == $past(count_q) + CW'(1))
		else $error("begin record without a stacked frame");

	a_end_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_CLOSE_EMIT) |=> count_q == $past(count_q) - CW'(1))
		else $error("end record without a removed frame");

	a_close_stops_at_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_CLOSE_EMIT && close_last) |=> count_q == $past(keep_q))
		else $error("close walk did not stop at the matched frame");

endmodule

`default_nettype wire

### src/nested_span_stack_tracker_top.sv
// ----------------------------------------------------------------------------
// Nested span stack tracker
// Push, pop and flush requests on a stack of open spans, emitting records.
// ----------------------------------------------------------------------------
// Each request word is taken only while the tracker is idle. A push reads
// the top frame and then loads its begin record; a dropped push loads its
// drop record instead. A pop reads and compares frames from the top of the
// stack down until a hash matches or the bottom is passed, then reads each
// frame to be closed and loads its end record; a flush does the same for
// every open frame; a request that changes nothing leaves the tracker idle.
// The walk goes through the single read port of the frame memory one entry
// at a time, and it stretches whenever the record output is stalled. A
// finished record sits in an output register, so a new request can be
// accepted while the last record still waits to be taken.
`default_nettype none

module nested_span_stack_tracker_top #(
	parameter int STACK_DEPTH = nsst_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nsst_pkg::APB_AW-1:0]   paddr,
	input  wire logic [nsst_pkg::APB_DW-1:0]   pwdata,
	output logic      [nsst_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	nsst_req_if.sink                           req,
	nsst_rec_if.source                         rec
);

	nsst_pkg::cfg_t cfg;

	nsst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nsst_core #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rec    (rec)
	);

endmodule

`default_nettype wire

### bench/nested_span_stack_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nested span stack tracker testbench
// Drives push, pop and flush requests through the request channel and
// register writes through the APB port. A shadow span stack or the script
// predicts every record, and each record word is compared in order.
// ----------------------------------------------------------------------------

module nested_span_stack_tracker_top_tb;

	import nsst_pkg::*;

	localparam int DEPTH        = STACK_DEPTH_DEF;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS  = 13;

	localparam logic [WORD_W-1:0] ONES = '1;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] CHK_MODEL = 2'd0;
	localparam logic [1:0] CHK_NONE  = 2'd1;
	localparam logic [1:0] CHK_ONE   = 2'd2;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] sid;
		logic [WORD_W-1:0] parent;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] tid;
		logic [WORD_W-1:0] stamp;
		logic              last;
	} span_rec_t;

	typedef struct packed {
		logic              is_cfg;
		logic [1:0]        code;
		logic [WORD_W-1:0] hash;
		logic [WORD_W-1:0] ts;
		logic [5:0]        reps;
		logic [1:0]        check;
		kind_t             kind;
		logic [WORD_W-1:0] sid;
		logic [WORD_W-1:0] parent;
	} step_t;

	localparam int SCRIPT_LEN = 26;
	localparam step_t SCRIPT [SCRIPT_LEN] = '{
		'{1'b0, REQ_PUSH, '0, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_FLUSH, ONES, ONES, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b1, REG_TRACING_ENABLED, 64'h1, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, 64'h5, 64'h10, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_POP, 64'h5, 64'h11, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_FLUSH, '0, 64'h12, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b1, REG_SESSION_ACTIVE, 64'h1, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b1, REG_THREAD_INDEX, ONES, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b1, REG_THREAD_HANDLE, 64'h0123_4567_89ab_cdef, '0, 6'd1, CHK_NONE,
			KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, ONES, ONES, 6'd1, CHK_ONE, KIND_BEGIN, 64'd1, 64'd0},
		'{1'b0, REQ_PUSH, '0, '0, 6'd1, CHK_ONE, KIND_BEGIN, 64'd2, 64'd1},
		'{1'b0, REQ_PUSH, 64'ha5a5, 64'h100, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_POP, '0, 64'h200, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_POP, 64'h7777, 64'h201, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_UNUSED, ONES, ONES, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, ONES, 64'h300, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_POP, ONES, 64'h301, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_FLUSH, '0, 64'h400, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b1, REG_THREAD_INDEX, '0, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, 64'h1000, 64'h500, 6'd32, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, 64'hdead, 64'h600, 6'd1, CHK_ONE, KIND_DROP, '0, '0},
		'{1'b0, REQ_POP, 64'h1003, 64'h700, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b1, REG_SESSION_ACTIVE, '0, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_PUSH, 64'h1, 64'h800, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0},
		'{1'b0, REQ_FLUSH, ONES, 64'h801, 6'd1, CHK_MODEL, KIND_BEGIN, '0, '0},
		'{1'b1, REG_THREAD_HANDLE, ONES, '0, 6'd1, CHK_NONE, KIND_BEGIN, '0, '0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	nsst_req_if req_ch ();
	nsst_rec_if rec_ch ();

	nested_span_stack_tracker_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rec     (rec_ch)
	);

	cfg_t              shadow_cfg;
	logic [WORD_W-1:0] shadow_hash [DEPTH];
	logic [WORD_W-1:0] shadow_sid [DEPTH];
	int                shadow_depth;
	logic [WORD_W-1:0] shadow_next_sid;

	span_rec_t pending_records [$];
	int        fail_count;
	int        quiet_cycles;
	bit        calm;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic close_spans(input int keep, input logic [WORD_W-1:0] ts);
		span_rec_t r;
		while (shadow_depth > keep) begin
			shadow_depth--;
			r.kind   = KIND_END;
			r.sid    = shadow_sid[shadow_depth];
			r.parent = '0;
			r.seq    = shadow_cfg.thread_index;
			r.tid    = '0;
			r.stamp  = ts;
			r.last   = (shadow_depth == keep);
			pending_records.insert(pending_records.size(), r);
		end
	endtask

	task automatic track_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] hash,
			input logic [WORD_W-1:0] ts);
		span_rec_t r;
		int i;
		r.seq   = shadow_cfg.thread_index;
		r.tid   = shadow_cfg.thread_handle;
		r.stamp = ts;
		r.last  = 1'b1;
		if (!shadow_cfg.tracing_enabled) begin
			return;
		end
		case (code)
			REQ_PUSH: begin
				if (!shadow_cfg.session_active) begin
					return;
				end
				if (shadow_depth >= DEPTH) begin
					r.kind   = KIND_DROP;
					r.sid    = '0;
					r.parent = '0;
				end else begin
					r.kind   = KIND_BEGIN;
					r.sid    = shadow_next_sid;
					r.parent = (shadow_depth == 0) ? '0 : shadow_sid[shadow_depth-1];
					shadow_hash[shadow_depth] = hash;
					shadow_sid[shadow_depth]  = shadow_next_sid;
					shadow_depth++;
					shadow_next_sid++;
				end
				pending_records.insert(pending_records.size(), r);
			end
			REQ_POP: begin
				if (!shadow_cfg.session_active) begin
					return;
				end
				for (i = shadow_depth; i > 0; i--) begin
					if (shadow_hash[i-1] == hash) begin
						close_spans(i - 1, ts);
						return;
					end
				end
			end
			REQ_FLUSH: begin
				close_spans(0, ts);
			end
			default: begin
			end
		endcase
	endtask

	task automatic csr_write(input logic [REG_SEL_W-1:0] sel, input logic [WORD_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = '0;
		paddr[REG_SEL_LSB +: REG_SEL_W] = sel;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (sel)
			REG_TRACING_ENABLED: shadow_cfg.tracing_enabled = value[0];
			REG_SESSION_ACTIVE:  shadow_cfg.session_active  = value[0];
			REG_THREAD_INDEX:    shadow_cfg.thread_index    = value;
			REG_THREAD_HANDLE:   shadow_cfg.thread_handle   = value;
			default: begin
			end
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_records_drained();
		req_ch.valid = 1'b0;
		while (pending_records.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic drain_tracker();
		wait_records_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] hash,
			input logic [WORD_W-1:0] ts, input logic [1:0] check, input span_rec_t typed);
		int queued;
		while (!calm && $urandom_range(0, 99) < 7) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.req_type     = code;
		req_ch.region_hash  = hash;
		req_ch.timestamp_ns = ts;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		queued = pending_records.size();
		track_request(code, hash, ts);
		if (check != CHK_MODEL) begin
			while (pending_records.size() > queued) begin
				pending_records.delete(pending_records.size() - 1);
			end
			if (check == CHK_ONE) begin
				pending_records.insert(pending_records.size(), typed);
			end
		end
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rec_ch.ready = calm || ($urandom_range(0, 99) >= 7);
	end

	always @(posedge clk) begin
		span_rec_t got;
		span_rec_t want;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			got.kind   = kind_t'(rec_ch.record_kind);
			got.sid    = rec_ch.span_id;
			got.parent = rec_ch.parent_id;
			got.seq    = rec_ch.thread_seq;
			got.tid    = rec_ch.thread_id;
			got.stamp  = rec_ch.record_time;
			got.last   = rec_ch.last;
			if (pending_records.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected record word: kind=%0d sid=%h time=%h", got.kind,
						got.sid, got.stamp);
				end
			end else begin
				want = pending_records.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("record mismatch: exp kind=%0d sid=%h parent=%h seq=%h tid=%h t=%h last=%b",
							want.kind, want.sid, want.parent, want.seq, want.tid, want.stamp, want.last);
						$display("                 got kind=%0d sid=%h parent=%h seq=%h tid=%h t=%h last=%b",
							got.kind, got.sid, got.parent, got.seq, got.tid, got.stamp, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("nested_span_stack_tracker_top_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int i;
		int r;
		int p;
		int sent;
		int counted;
		int pick;
		logic [REQ_W-1:0] code;
		logic [WORD_W-1:0] hash;
		logic [WORD_W-1:0] pool [6];
		span_rec_t typed;
		step_t s;

		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_PUSH;
		req_ch.region_hash  = '0;
		req_ch.timestamp_ns = '0;
		calm                = 1'b0;
		fail_count          = 0;
		shadow_cfg          = '0;
		shadow_depth        = 0;
		shadow_next_sid     = 64'd1;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < SCRIPT_LEN; i++) begin
			s = SCRIPT[i];
			if (s.is_cfg) begin
				drain_tracker();
				csr_write(s.code, s.hash);
			end else begin
				for (r = 0; r < s.reps; r++) begin
					typed.kind   = s.kind;
					typed.sid    = s.sid;
					typed.parent = s.parent;
					typed.seq    = shadow_cfg.thread_index;
					typed.tid    = (s.kind == KIND_END) ? '0 : shadow_cfg.thread_handle;
					typed.stamp  = s.ts;
					typed.last   = 1'b1;
					send_request(s.code, s.hash + r, s.ts, s.check, typed);
				end
			end
		end

		typed = '0;
		for (p = 0; p < 6; p++) begin
			drain_tracker();
			calm = (p == 4);
			csr_write(REG_TRACING_ENABLED, {63'd0, p != 2});
			csr_write(REG_SESSION_ACTIVE, {63'd0, p != 3});
			csr_write(REG_THREAD_INDEX, (p == 0) ? '0 : (p == 4) ? ONES : rand_word());
			csr_write(REG_THREAD_HANDLE, (p == 0) ? '0 : (p == 4) ? ONES : rand_word());
			for (i = 0; i < 6; i++) begin
				pool[i] = rand_word();
			end
			sent    = 0;
			counted = 0;
			while ((shadow_cfg.tracing_enabled && shadow_cfg.session_active)
					? counted < PHASE_ITEMS : sent < 12) begin
				if (sent == 10) begin
					wait_records_drained();
				end
				pick = $urandom_range(0, 99);
				if (pick < 53) begin
					code = REQ_PUSH;
				end else if (pick < 87) begin
					code = REQ_POP;
				end else if (pick < 93) begin
					code = REQ_FLUSH;
				end else begin
					code = REQ_UNUSED;
				end
				hash = ($urandom_range(0, 9) == 0) ? rand_word() : pool[$urandom_range(0, 5)];
				if (shadow_cfg.tracing_enabled && (code == REQ_FLUSH
						|| (shadow_cfg.session_active && code != REQ_UNUSED))) begin
					counted++;
				end
				send_request(code, hash, rand_word(), CHK_MODEL, typed);
				sent++;
			end
		end
		calm = 1'b0;

		drain_tracker();
		if (pending_records.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("nested_span_stack_tracker_top_tb OK");
		end else begin
			$display("nested_span_stack_tracker_top_tb NOT OK");
		end
		$finish;
	end

endmodule
